>>> hdl/pac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_pkg
// Shared types and constants of the polygon area and centroid core: request
// and result payloads, status codes, and the controller to datapath bundles.
// ----------------------------------------------------------------------------
package pac_pkg;

   localparam int COORD_W    = 16;
   localparam int AREA_OUT_W = 37;
   localparam int EPS_W      = 16;
   localparam int EPS_RESET  = 1;

   localparam logic [AREA_OUT_W-1:0] AREA_MAX = '1;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_DEGENERATE = 2'd1,
      ST_NEG_ORIENT = 2'd2,
      ST_OVERFLOW   = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic                      last_vertex;
   } req_payload_type;

   typedef struct packed {
      logic [AREA_OUT_W-1:0]     area;
      logic signed [COORD_W-1:0] centroid_x;
      logic signed [COORD_W-1:0] centroid_y;
      status_type                status;
   } rsp_payload_type;

   typedef enum logic {
      AXIS_X = 1'b0,
      AXIS_Y = 1'b1
   } axis_type;

   typedef struct packed {
      logic     capture;
      logic     accum;
      logic     close;
      logic     judge;
      logic     div_start;
      axis_type div_axis;
      logic     div_step;
      logic     div_store;
      logic     emit;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
      logic result_ok;
      logic div_done;
      logic out_free;
   } dp_sts_type;

endpackage

>>> hdl/pac_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_ctrl
// Sequencer of the polygon core: takes one vertex, runs the accumulate step;
// on the last one closes, checks, runs both centroid divisions if ok, emits.
// ----------------------------------------------------------------------------
module pac_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pac_pkg::dp_sts_type sts,
   output pac_pkg::dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ACCUM,
      S_CLOSE,
      S_CLOSE_ACCUM,
      S_JUDGE,
      S_DIV_X,
      S_ROUND_X,
      S_DIV_Y,
      S_ROUND_Y,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.div_axis  = pac_pkg::AXIS_X;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_ACCUM;
            end
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = sts.last ? S_CLOSE : S_IDLE;
         end
         S_CLOSE: begin
            cmd.close = 1'b1;
            state_in  = S_CLOSE_ACCUM;
         end
         S_CLOSE_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = S_JUDGE;
         end
         S_JUDGE: begin
            cmd.judge     = 1'b1;
            cmd.div_start = sts.result_ok;
            cmd.div_axis  = pac_pkg::AXIS_X;
            state_in      = sts.result_ok ? S_DIV_X : S_EMIT;
         end
         S_DIV_X: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = S_ROUND_X;
            end
         end
         S_ROUND_X: begin
            cmd.div_store = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_axis  = pac_pkg::AXIS_Y;
            state_in      = S_DIV_Y;
         end
         S_DIV_Y: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = S_ROUND_Y;
            end
         end
         S_ROUND_Y: begin
            cmd.div_store = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/pac_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_datapath
// Shoelace datapath: edge cross product, area and moment accumulators,
// status check, bit-serial restoring divider and the result register.
// ----------------------------------------------------------------------------
module pac_datapath #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pac_pkg::req_payload_type   req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output pac_pkg::rsp_payload_type   rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [pac_pkg::EPS_W-1:0]  csr_data,
   input  pac_pkg::dp_cmd_type        cmd,
   output pac_pkg::dp_sts_type        sts
);

   localparam int CW      = pac_pkg::COORD_W;
   localparam int CROSS_W = 2 * CW + 1;
   localparam int SUMC_W  = CW + 1;
   localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
   localparam int AREA_W  = CROSS_W + CNT_W;
   localparam int MOM_W   = AREA_W + SUMC_W;
   localparam int PROD_W  = CROSS_W + SUMC_W;
   localparam int DEN_W   = AREA_W + 2;
   localparam int DCNT_W  = $clog2(MOM_W);
   localparam int AOW     = pac_pkg::AREA_OUT_W;
   localparam int CMP_W   = (AREA_W > AOW + 1) ? AREA_W : AOW + 1;
   localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_VERTICES);
   localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(MOM_W - 1);
   localparam logic [MOM_W:0]    LIM_POS   = (MOM_W + 1)'((1 << (CW - 1)) - 1);
   localparam logic [MOM_W:0]    LIM_NEG   = (MOM_W + 1)'(1 << (CW - 1));

   // csr
   logic [pac_pkg::EPS_W-1:0] eps_ff;

   // polygon state
   logic signed [CW-1:0]      first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      overflow_ff;
   logic                      last_ff;
   logic signed [CROSS_W-1:0] cross_ff;
   logic signed [SUMC_W-1:0]  sum_x_ff, sum_y_ff;
   logic signed [AREA_W-1:0]  twice_area_ff;
   logic signed [MOM_W-1:0]   mom_x_ff, mom_y_ff;

   // divider
   logic [DEN_W-1:0]          den_ff;
   logic [DEN_W-1:0]          rem_ff;
   logic [MOM_W-1:0]          quot_ff;
   logic [DCNT_W-1:0]         dcnt_ff;
   logic                      div_neg_ff;
   pac_pkg::axis_type         axis_ff;

   // result
   logic                      rsp_valid_ff;
   logic [AOW-1:0]            area_ff;
   logic signed [CW-1:0]      cen_x_ff, cen_y_ff;
   pac_pkg::status_type       status_ff;

   // edge unit
   logic signed [CW-1:0]      edge_bx, edge_by;
   logic                      edge_live;
   logic signed [2*CW-1:0]    prod_a, prod_b;
   logic signed [CROSS_W-1:0] cross_in;
   logic signed [SUMC_W-1:0]  sum_x_in, sum_y_in;
   logic signed [PROD_W-1:0]  mprod_x, mprod_y;

   // check
   logic                      area_neg;
   logic [AREA_W-1:0]         area_mag;
   logic [CMP_W-1:0]          half_area;
   logic [AOW-1:0]            area_sat;
   pac_pkg::status_type       status_in;
   logic [DEN_W-1:0]          den_in;

   // divider step and rounding
   logic signed [MOM_W-1:0]   div_src;
   logic [MOM_W-1:0]          div_mag;
   logic [DEN_W:0]            trial;
   logic                      trial_ge;
   logic [DEN_W-1:0]          rem_in;
   logic                      round_up;
   logic [MOM_W:0]            q_round;
   logic [MOM_W:0]            q_sat;
   logic [MOM_W:0]            q_neg;
   logic signed [CW-1:0]      cen_in;

   assign csr_ready = 1'b1;

   always_comb begin
      edge_bx   = cmd.close ? first_x_ff : req_payload.vertex_x;
      edge_by   = cmd.close ? first_y_ff : req_payload.vertex_y;
      edge_live = cmd.close ? (!overflow_ff && count_ff != '0)
                            : (count_ff != '0 && count_ff < CNT_MAX);
      prod_a    = prev_x_ff * edge_by;
      prod_b    = edge_bx * prev_y_ff;
      cross_in  = edge_live ? (CROSS_W'(prod_a) - CROSS_W'(prod_b)) : '0;
      sum_x_in  = SUMC_W'(prev_x_ff) + SUMC_W'(edge_bx);
      sum_y_in  = SUMC_W'(prev_y_ff) + SUMC_W'(edge_by);
      mprod_x   = cross_ff * sum_x_ff;
      mprod_y   = cross_ff * sum_y_ff;
   end

   always_comb begin
      area_neg  = twice_area_ff[AREA_W-1];
      area_mag  = area_neg ? $unsigned(-twice_area_ff) : $unsigned(twice_area_ff);
      half_area = CMP_W'($unsigned(twice_area_ff) >> 1);
      area_sat  = (half_area > CMP_W'(pac_pkg::AREA_MAX)) ? pac_pkg::AREA_MAX
                                                          : half_area[AOW-1:0];
      if (overflow_ff) begin
         status_in = pac_pkg::ST_OVERFLOW;
      end else if (area_mag <= AREA_W'(eps_ff)) begin
         status_in = pac_pkg::ST_DEGENERATE;
      end else if (area_neg) begin
         status_in = pac_pkg::ST_NEG_ORIENT;
      end else begin
         status_in = pac_pkg::ST_OK;
      end
      den_in = DEN_W'($unsigned(twice_area_ff)) + (DEN_W'($unsigned(twice_area_ff)) << 1);
   end

   always_comb begin
      div_src  = (cmd.div_axis == pac_pkg::AXIS_Y) ? mom_y_ff : mom_x_ff;
      div_mag  = div_src[MOM_W-1] ? $unsigned(-div_src) : $unsigned(div_src);
      trial    = {rem_ff, quot_ff[MOM_W-1]};
      trial_ge = (trial >= {1'b0, den_ff});
      rem_in   = trial_ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
      round_up = ({rem_ff, 1'b0} >= {1'b0, den_ff});
      q_round  = {1'b0, quot_ff} + (MOM_W + 1)'(round_up);
      if (div_neg_ff) begin
         q_sat = (q_round > LIM_NEG) ? LIM_NEG : q_round;
      end else begin
         q_sat = (q_round > LIM_POS) ? LIM_POS : q_round;
      end
      q_neg  = -q_sat;
      cen_in = div_neg_ff ? $signed(q_neg[CW-1:0]) : $signed(q_sat[CW-1:0]);
   end

   assign sts.last      = last_ff;
   assign sts.result_ok = (status_in == pac_pkg::ST_OK);
   assign sts.div_done  = (dcnt_ff == '0);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= pac_pkg::EPS_W'(pac_pkg::EPS_RESET);
      end else if (csr_valid && csr_ready) begin
         eps_ff <= csr_data;
      end
   end

   // vertex bookkeeping and accumulators
   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         twice_area_ff <= '0;
         mom_x_ff      <= '0;
         mom_y_ff      <= '0;
      end else begin
         if (cmd.capture) begin
            if (count_ff >= CNT_MAX) begin
               overflow_ff <= 1'b1;
            end else begin
               if (count_ff == '0) begin
                  first_x_ff <= req_payload.vertex_x;
                  first_y_ff <= req_payload.vertex_y;
               end
               prev_x_ff <= req_payload.vertex_x;
               prev_y_ff <= req_payload.vertex_y;
               count_ff  <= count_ff + CNT_W'(1);
            end
         end
         if (cmd.accum) begin
            twice_area_ff <= twice_area_ff + AREA_W'(cross_ff);
            mom_x_ff      <= mom_x_ff + MOM_W'(mprod_x);
            mom_y_ff      <= mom_y_ff + MOM_W'(mprod_y);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         last_ff <= req_payload.last_vertex;
      end
      if (cmd.capture || cmd.close) begin
         cross_ff <= cross_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
      end
   end

   // check, divider and result fields
   always_ff @(posedge clock) begin
      if (cmd.judge) begin
         status_ff <= status_in;
         area_ff   <= (status_in == pac_pkg::ST_OK) ? area_sat : '0;
         cen_x_ff  <= '0;
         cen_y_ff  <= '0;
         den_ff    <= den_in;
      end
      if (cmd.div_store) begin
         if (axis_ff == pac_pkg::AXIS_Y) begin
            cen_y_ff <= cen_in;
         end else begin
            cen_x_ff <= cen_in;
         end
      end
      if (cmd.div_start) begin
         quot_ff    <= div_mag;
         rem_ff     <= '0;
         dcnt_ff    <= DCNT_LAST;
         div_neg_ff <= div_src[MOM_W-1];
         axis_ff    <= cmd.div_axis;
      end else if (cmd.div_step) begin
         quot_ff <= {quot_ff[MOM_W-2:0], trial_ge};
         rem_ff  <= rem_in;
         dcnt_ff <= dcnt_ff - DCNT_W'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_payload.area       <= area_ff;
         rsp_payload.centroid_x <= cen_x_ff;
         rsp_payload.centroid_y <= cen_y_ff;
         rsp_payload.status     <= status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/polygon_area_centroid_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_area_centroid_core
// Streams polygon vertices and returns the shoelace area and centroid of
// each polygon, one result per vertex flagged last.
// ----------------------------------------------------------------------------
// A vertex that is not flagged last goes through an edge cross product step
// and then an area and moment accumulate step. The last vertex of a polygon
// whose status comes out ok also closes and checks the polygon and runs the
// one-bit-per-cycle divider once for each centroid coordinate, to a MOM_W-bit
// quotient, where MOM_W = 33 + clog2(MAX_VERTICES + 1) + 17; a last vertex
// with any other status skips the divider. Either way the core then waits to
// emit while the result side stalls an earlier result that is still held.
// The result sits in an output register, so new vertices are taken while it
// waits. The threshold register may be written at any time while idle.
module polygon_area_centroid_core #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  pac_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output pac_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [pac_pkg::EPS_W-1:0] csr_data
);

   pac_pkg::dp_cmd_type cmd;
   pac_pkg::dp_sts_type sts;

   pac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pac_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule
